// ===== sv/lqls_pkg.sv =====
// Package for the linear-quadratic-linear survival evaluator.
// Holds field widths, register indexes, fixed-point constants and the
// elaboration-time square root used to build the exp factor table.
package lqls_pkg;

	localparam int EXP_TABLE_BITS_DEF = 8;

	localparam int DOSE_W     = 24;
	localparam int COEF_W     = 20;
	localparam int EVENTS_W   = 32;
	localparam int SURV_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL  = 2'd3;

	localparam logic [DOSE_W-1:0] TRANS_RESET = 24'hFF_FFFF;

	// log2(e) and ln(2) in Q.30, and the Q.30 value of one.
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [61:0] HALF_Q30  = 62'h2000_0000;

	// Items travel through the exp pipeline with their event count.
	typedef struct packed {
		logic [EVENTS_W-1:0] events;
		logic                sat;
	} lqls_tag_t;

	// Integer square root, bit by bit; used only on constants.
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bit_m;
		v     = v_in;
		res   = 64'd0;
		bit_m = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + bit_m) begin
				v   = v - (res + bit_m);
				res = (res >> 1) + bit_m;
			end else begin
				res = res >> 1;
			end
			bit_m = bit_m >> 2;
		end
		return res;
	endfunction

	// Factor 2^(-2^-k) in Q.30, built by repeated square roots from 2^-0.5.
	function automatic logic [29:0] exp_factor(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int j = 1; j < k; j++) begin
			c = isqrt64(c << 30);
		end
		return c[29:0];
	endfunction

endpackage

// ===== sv/lqls_exp_unit.sv =====
// Pipelined exp(-L) unit: base-2 range reduction, one table factor per
// stage, then a quadratic correction and the final shift.
// Depends on lqls_pkg.
module lqls_exp_unit import lqls_pkg::*; #(
	parameter int TABLE_BITS = EXP_TABLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  lqls_tag_t         in_tag,
	output logic              out_valid,
	output lqls_tag_t         out_tag,
	output logic [SURV_W-1:0] survival
);

	localparam int R_W = 30 - TABLE_BITS;

	// Stage 1: exponent y = L * log2(e) in Q17.46.
	logic [62:0] y;
	logic        under;
	logic [4:0]  sh;

	assign y     = 63'(in_tag.events) * 63'(LOG2E_Q30);
	assign under = y[62:46] >= 17'd18;
	assign sh    = y[50:46] + 5'd14;

	logic        v_s1;
	logic [45:0] f_s1;
	logic [4:0]  sh_s1;
	logic        un_s1;
	lqls_tag_t   tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= y[45:0];
			sh_s1  <= sh;
			un_s1  <= under;
			tag_s1 <= in_tag;
		end
	end

	// Table stages: stage k multiplies by 2^(-2^-k) when fraction bit k is set.
	logic        tv_s   [1:TABLE_BITS];
	logic [30:0] tm_s   [1:TABLE_BITS];
	logic [45:0] tf_s   [1:TABLE_BITS];
	logic [4:0]  tsh_s  [1:TABLE_BITS];
	logic        tun_s  [1:TABLE_BITS];
	lqls_tag_t   ttag_s [1:TABLE_BITS];

	for (genvar k = 1; k <= TABLE_BITS; k++) begin : g_tbl
		localparam logic [29:0] CK = exp_factor(k);

		logic        v_in;
		logic [30:0] m_in;
		logic [45:0] f_in;
		logic [4:0]  sh_in;
		logic        un_in;
		lqls_tag_t   tag_in;
		logic [61:0] prod;
		logic [30:0] m_next;

		if (k == 1) begin : g_first
			assign v_in   = v_s1;
			assign m_in   = ONE_Q30;
			assign f_in   = f_s1;
			assign sh_in  = sh_s1;
			assign un_in  = un_s1;
			assign tag_in = tag_s1;
		end else begin : g_next
			assign v_in   = tv_s[k-1];
			assign m_in   = tm_s[k-1];
			assign f_in   = tf_s[k-1];
			assign sh_in  = tsh_s[k-1];
			assign un_in  = tun_s[k-1];
			assign tag_in = ttag_s[k-1];
		end

		assign prod   = 62'(m_in) * 62'(CK) + HALF_Q30;
		assign m_next = f_in[46-k] ? prod[60:30] : m_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tv_s[k] <= 1'b0;
			end else if (en) begin
				tv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tm_s[k]   <= m_next;
				tf_s[k]   <= f_in;
				tsh_s[k]  <= sh_in;
				tun_s[k]  <= un_in;
				ttag_s[k] <= tag_in;
			end
		end
	end

	logic        v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [28:0] x_s2, x_s3;
	logic [26:0] xx_s3;
	logic [30:0] p_s4;
	logic [30:0] m_s2, m_s3, m_s4, m_s5;
	logic [4:0]  sh_s2, sh_s3, sh_s4, sh_s5;
	logic        un_s2, un_s3, un_s4, un_s5;
	lqls_tag_t   tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic [SURV_W-1:0] surv_s6;

	// Stage 2: x = r * ln2 from the fraction bits the table did not use.
	logic [R_W-1:0] r;
	logic [61:0]    xprod;

	assign r     = tf_s[TABLE_BITS][45-TABLE_BITS:16];
	assign xprod = 62'(r) * 62'(LN2_Q30) + HALF_Q30;

	// Stage 3: x squared; stage 4: p = 1 - x + x^2/2.
	logic [57:0] xsq;
	logic [30:0] p;

	assign xsq = 58'(x_s2) * 58'(x_s2);
	assign p   = ONE_Q30 - 31'(x_s3) + 31'(xx_s3);

	// Stage 5: m * p; stage 6: scale by 2^-n with rounding.
	logic [61:0] mp;
	logic [31:0] rnd;
	logic [31:0] shifted;

	assign mp      = 62'(m_s4) * 62'(p_s4) + HALF_Q30;
	assign rnd     = 32'(m_s5) + (32'd1 << (sh_s5 - 5'd1));
	assign shifted = rnd >> sh_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s2 <= tv_s[TABLE_BITS];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= xprod[58:30];
			m_s2    <= tm_s[TABLE_BITS];
			sh_s2   <= tsh_s[TABLE_BITS];
			un_s2   <= tun_s[TABLE_BITS];
			tag_s2  <= ttag_s[TABLE_BITS];

			x_s3    <= x_s2;
			xx_s3   <= xsq[57:31];
			m_s3    <= m_s2;
			sh_s3   <= sh_s2;
			un_s3   <= un_s2;
			tag_s3  <= tag_s2;

			p_s4    <= p;
			m_s4    <= m_s3;
			sh_s4   <= sh_s3;
			un_s4   <= un_s3;
			tag_s4  <= tag_s3;

			m_s5    <= mp[60:30];
			sh_s5   <= sh_s4;
			un_s5   <= un_s4;
			tag_s5  <= tag_s4;

			surv_s6 <= un_s5 ? '0 : shifted[SURV_W-1:0];
			tag_s6  <= tag_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_tag   = tag_s6;
	assign survival  = surv_s6;

endmodule

// ===== sv/lq_linear_survival_eval_top.sv =====
// Top level of the linear-quadratic-linear survival evaluator.
// Holds the configuration registers and the lethal-event pipeline, and
// instantiates lqls_exp_unit. Depends on lqls_pkg.
//
// Usage:
// - Configuration: write alpha_coeff (index 0), beta_coeff (1),
//   transition_dose (2) and tail_slope (3) on the cfg channel while no word
//   is in flight. cfg_ready is always high.
// - Input: one dose word per in_valid/in_ready handshake, Q8.16 gray.
// - Output: lethal_events (Q16.16, saturating), survival (Q1.16, 65536 is
//   one) and events_saturated, one result word per dose, in order.
// - Throughput: one word per cycle, sustained while out_ready does not stall it.
// - Depth: the pipeline is made of four lethal-event stages, the exponent
//   multiply, one stage per exp table factor and five correction and
//   scaling stages.
// - Stall: the whole pipeline holds while a result word waits on
//   out_ready; in_ready stays high whenever the output register is empty
//   or is being taken, so bubbles never block new words.
// - Reset: arst_n empties the pipeline and loads the register defaults
//   (coefficients zero, transition dose at its maximum).
module lq_linear_survival_eval_top import lqls_pkg::*; #(
	parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DOSE_W-1:0]     dose,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [EVENTS_W-1:0]   lethal_events,
	output logic [SURV_W-1:0]     survival,
	output logic                  events_saturated
);

	logic [COEF_W-1:0] alpha_q;
	logic [COEF_W-1:0] beta_q;
	logic [DOSE_W-1:0] trans_q;
	logic [DOSE_W-1:0] tail_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q  <= '0;
			trans_q <= TRANS_RESET;
			tail_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data[COEF_W-1:0];
				REG_BETA:  beta_q  <= cfg_data[COEF_W-1:0];
				REG_TRANS: trans_q <= cfg_data[DOSE_W-1:0];
				REG_TAIL:  tail_q  <= cfg_data[DOSE_W-1:0];
				default:   alpha_q <= alpha_q;
			endcase
		end
	end

	// The pipeline moves as one whenever the output register can take a word.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: clip at the transition dose.
	logic              v_s1;
	logic [DOSE_W-1:0] dc_s1;
	logic [DOSE_W-1:0] ex_s1;

	// Stage 2: dc^2 in Q16.16, alpha and tail products.
	logic        v_s2;
	logic [47:0] sq_full;
	logic [31:0] sq_s2;
	logic [43:0] ap_s2;
	logic [47:0] tp_s2;

	// Stage 3: beta product, linear terms summed.
	logic        v_s3;
	logic [51:0] bp_s3;
	logic [48:0] at_s3;

	// Stage 4: round to Q16.16 and saturate.
	logic        v_s4;
	logic [52:0] sum;
	logic [36:0] ev;
	lqls_tag_t   tag_s4;

	assign sq_full = 48'(dc_s1) * 48'(dc_s1);
	assign sum     = 53'(bp_s3) + 53'(at_s3) + 53'd32768;
	assign ev      = sum[52:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dc_s1 <= (dose < trans_q) ? dose : trans_q;
			ex_s1 <= (dose < trans_q) ? '0 : dose - trans_q;

			sq_s2 <= sq_full[47:16];
			ap_s2 <= 44'(alpha_q) * 44'(dc_s1);
			tp_s2 <= 48'(tail_q) * 48'(ex_s1);

			bp_s3 <= 52'(beta_q) * 52'(sq_s2);
			at_s3 <= 49'(ap_s2) + 49'(tp_s2);

			tag_s4.sat    <= |ev[36:32];
			tag_s4.events <= (|ev[36:32]) ? '1 : ev[31:0];
		end
	end

	lqls_tag_t out_tag;

	lqls_exp_unit #(
		.TABLE_BITS(EXP_TABLE_BITS)
	) u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.in_tag   (tag_s4),
		.out_valid(out_valid),
		.out_tag  (out_tag),
		.survival (survival)
	);

	assign lethal_events    = out_tag.events;
	assign events_saturated = out_tag.sat;

`ifndef SYNTHESIS
	a_sat_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && events_saturated |-> lethal_events == '1)
		else $error("saturated word without full-scale event count");

	a_surv_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> survival <= 17'd65536)
		else $error("survival above one");

	a_zero_events: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lethal_events == '0 |-> survival == 17'd65536)
		else $error("zero events must give survival of one");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");
`endif

endmodule

// ===== tb/tb_lq_linear_survival_eval_top.sv =====
// Self-checking testbench for lq_linear_survival_eval_top: random and directed dose
// words against an in-bench fixed-point prediction of lethal events and survival.
// Depends on lqls_pkg and the top level RTL only.
`timescale 1ns / 1ps

module tb_lq_linear_survival_eval_top;
	import lqls_pkg::*;

	localparam int EXP_BITS      = EXP_TABLE_BITS_DEF;
	localparam int LATENCY       = EXP_BITS + 9;
	localparam int STALL_LIMIT   = 4000;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 110;
	localparam int MAX_REPORTS   = 100;

	localparam logic [63:0] LOG2E_FX = 64'd1549082005;
	localparam logic [63:0] LN2_FX   = 64'd744261118;
	localparam logic [63:0] ONE_FX   = 64'd1 << 30;
	localparam logic [63:0] HALF_FX  = 64'd1 << 29;

	typedef struct {
		logic [EVENTS_W-1:0] events;
		logic [SURV_W-1:0]   surv;
		logic                sat;
	} outcome_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [DOSE_W-1:0]     dose      = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [EVENTS_W-1:0]   lethal_events;
	logic [SURV_W-1:0]     survival;
	logic                  events_saturated;

	// Shadow copy of the register file, updated on each accepted write.
	logic [COEF_W-1:0] alpha_q16  = '0;
	logic [COEF_W-1:0] beta_q16   = '0;
	logic [DOSE_W-1:0] trans_dose = TRANS_RESET;
	logic [DOSE_W-1:0] tail_rate  = '0;

	logic [63:0]       root_factor [1:EXP_BITS];
	logic [DOSE_W-1:0] dose_q[$];
	outcome_t          predicted_q[$];

	int err_count   = 0;
	int hold_req    = 0;
	int hold_done   = 0;
	int idle_cycles = 0;
	bit calm        = 1'b0;
	// Follows in_valid at once, so a word just taken from the queue counts as in flight.
	bit offering    = 1'b0;

	lq_linear_survival_eval_top #(
		.EXP_TABLE_BITS(EXP_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.dose(dose),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.lethal_events(lethal_events),
		.survival(survival),
		.events_saturated(events_saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Floor of the square root by bisection; the arguments stay below 2^62.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		lo = 64'd0;
		hi = 64'd1 << 31;
		while (hi - lo > 64'd1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= v) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	// exp(-events) in Q1.16, through 2^(-events*log2 e).
	function automatic logic [SURV_W-1:0] exp_neg_q16(input logic [EVENTS_W-1:0] ev);
		logic [63:0] y;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] m;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] p;
		y = 64'(ev) * LOG2E_FX;
		n = y >> 46;
		f = y & ((64'd1 << 46) - 64'd1);
		if (n >= 64'd18) return '0;
		m = ONE_FX;
		for (int k = 1; k <= EXP_BITS; k++) begin
			if (f[46 - k]) m = (m * root_factor[k] + HALF_FX) >> 30;
		end
		// The fraction bits below the table go through a second-order series.
		r = (f & ((64'd1 << (46 - EXP_BITS)) - 64'd1)) >> 16;
		x = (r * LN2_FX + HALF_FX) >> 30;
		p = ONE_FX - x + ((x * x) >> 31);
		m = (m * p + HALF_FX) >> 30;
		return SURV_W'((m + (64'd1 << (13 + n))) >> (14 + n));
	endfunction

	function automatic outcome_t lq_predict(input logic [DOSE_W-1:0] d);
		logic [63:0] dw;
		logic [63:0] dc;
		logic [63:0] excess;
		logic [63:0] sq;
		logic [63:0] acc;
		logic [63:0] ev;
		outcome_t    res;
		dw = 64'(d);
		dc = (dw < 64'(trans_dose)) ? dw : 64'(trans_dose);
		excess = dw - dc;
		sq = (dc * dc) >> 16;
		acc = 64'(alpha_q16) * dc + 64'(beta_q16) * sq + 64'(tail_rate) * excess;
		ev = (acc + 64'h8000) >> 16;
		res.sat = (ev > 64'hFFFF_FFFF);
		res.events = res.sat ? '1 : ev[EVENTS_W-1:0];
		res.surv = exp_neg_q16(res.events);
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (calm) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [31:0] wild_value(input int width);
		case ($urandom_range(0, 5))
			0: begin
				return 32'd0;
			end
			1: begin
				return (32'd1 << width) - 32'd1;
			end
			default: begin
				return $urandom >> $urandom_range(32 - width, 31);
			end
		endcase
	endfunction

	task automatic check_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ALPHA: begin
				alpha_q16 = data[COEF_W-1:0];
			end
			REG_BETA: begin
				beta_q16 = data[COEF_W-1:0];
			end
			REG_TRANS: begin
				trans_dose = data[DOSE_W-1:0];
			end
			REG_TAIL: begin
				tail_rate = data[DOSE_W-1:0];
			end
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Returns once every queued dose has gone in and every result word is back.
	task automatic wait_idle();
		while (dose_q.size() != 0 || offering || predicted_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : dose_driver
		int send_gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			dose     <= '0;
			send_gap = 0;
			offering = 1'b0;
		end else begin
			if (in_valid && in_ready)
				predicted_q.push_back(lq_predict(dose));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
					offering = 1'b0;
				end else if (dose_q.size() != 0) begin
					dose     <= dose_q.pop_front();
					in_valid <= 1'b1;
					offering = 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
					offering = 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_checker
		int       stall;
		outcome_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_q.size() == 0) begin
					err_count++;
					$display("%0t: result word with no dose pending, got events %0d survival %0d",
						$time, lethal_events, survival);
				end else begin
					want = predicted_q.pop_front();
					check_field("lethal_events", want.events, lethal_events);
					check_field("survival", 32'(want.surv), 32'(survival));
					check_field("events_saturated", 32'(want.sat), 32'(events_saturated));
				end
			end
			if (hold_req != hold_done) begin
				hold_done++;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watchdog
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [63:0]       c;
		logic [31:0]       val;
		logic [DOSE_W-1:0] d;
		int                t;
		int                roll;
		bit                clinical;

		c = floor_sqrt(64'd1 << 59);
		for (int k = 1; k <= EXP_BITS; k++) begin
			root_factor[k] = c;
			c = floor_sqrt(c << 30);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: no events at any dose, so survival is exactly one.
		dose_q.push_back(24'h00_0000);
		dose_q.push_back(24'hFF_FFFF);
		dose_q.push_back(24'h80_0000);

		// Steep tail past 1 Gy drives the event sum near full scale, short of saturation.
		// Alpha is written with its unused upper bits set.
		wait_idle();
		write_reg(REG_ALPHA, 24'hFF_FFFF);
		write_reg(REG_BETA, 24'h00_0000);
		write_reg(REG_TRANS, 24'h01_0000);
		write_reg(REG_TAIL, 24'hFF_FFFF);
		dose_q.push_back(24'h00_0000);
		dose_q.push_back(24'h00_FFFF);
		dose_q.push_back(24'h01_0000);
		dose_q.push_back(24'h01_0001);
		dose_q.push_back(24'hFF_FFFF);

		// Typical tissue values: shoulder up to 10 Gy, then a linear tail.
		wait_idle();
		write_reg(REG_ALPHA, 24'h00_4CCD);
		write_reg(REG_BETA, 24'h00_07AE);
		write_reg(REG_TRANS, 24'h0A_0000);
		write_reg(REG_TAIL, 24'h00_A000);
		dose_q.push_back(24'h00_0001);
		dose_q.push_back(24'h02_0000);
		dose_q.push_back(24'h09_FFFF);
		dose_q.push_back(24'h0A_0000);
		dose_q.push_back(24'h0A_0001);
		dose_q.push_back(24'h14_0000);
		dose_q.push_back(24'hFF_FFFF);

		// Pure quadratic with the largest beta and no transition.
		wait_idle();
		write_reg(REG_ALPHA, 24'h00_0000);
		write_reg(REG_BETA, 24'hFF_FFFF);
		write_reg(REG_TRANS, 24'hFF_FFFF);
		write_reg(REG_TAIL, 24'h00_0000);
		dose_q.push_back(24'hFF_FFFF);
		dose_q.push_back(24'h00_0100);
		dose_q.push_back(24'h01_0000);

		// Transition at zero: the whole dose goes through the tail slope.
		wait_idle();
		write_reg(REG_TRANS, 24'h00_0000);
		write_reg(REG_TAIL, 24'h00_B172);
		dose_q.push_back(24'h01_0000);
		dose_q.push_back(24'h08_0000);
		dose_q.push_back(24'h1A_0000);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			calm = (ph % 3 == 1);
			clinical = ($urandom_range(0, 2) != 0);
			if (ph == 0 || $urandom_range(0, 3) != 0) begin
				val = clinical ? $urandom_range(0, 32'h1_0000) : wild_value(COEF_W);
				write_reg(REG_ALPHA, {4'($urandom_range(0, 15)), val[COEF_W-1:0]});
			end
			if (ph == 0 || $urandom_range(0, 3) != 0) begin
				val = clinical ? $urandom_range(0, 32'h3333) : wild_value(COEF_W);
				write_reg(REG_BETA, {4'($urandom_range(0, 15)), val[COEF_W-1:0]});
			end
			if (ph == 0 || $urandom_range(0, 3) != 0) begin
				val = clinical ? $urandom_range(32'h2_0000, 32'h14_0000) : wild_value(DOSE_W);
				write_reg(REG_TRANS, val[DOSE_W-1:0]);
			end
			if (ph == 0 || $urandom_range(0, 3) != 0) begin
				val = clinical ? $urandom_range(0, 32'h2_0000) : wild_value(DOSE_W);
				write_reg(REG_TAIL, val[DOSE_W-1:0]);
			end

			for (int i = 0; i < PHASE_WORDS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 20) begin
					// Around the transition dose, clipped to the field range.
					t = int'(trans_dose);
					t = t + int'($urandom_range(0, 8)) - 4;
					if (t < 0) t = 0;
					if (t > 32'hFF_FFFF) t = 32'hFF_FFFF;
					d = t[DOSE_W-1:0];
				end else if (clinical && roll < 85) begin
					d = DOSE_W'($urandom_range(0, 32'h1E_0000));
				end else if (roll < 60) begin
					d = DOSE_W'($urandom_range(0, 32'hFF_FFFF));
				end else begin
					d = DOSE_W'($urandom_range(0, 32'hFF_FFFF) >> $urandom_range(0, 23));
				end
				dose_q.push_back(d);
			end
			// Hold the result side off long enough to back the pipeline up.
			if (ph == 2) hold_req++;
		end

		wait_idle();
		repeat (2 * LATENCY) @(posedge clk);
		if (err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
